FILE: rtl/core/stoq_pkg.sv
package stoq_pkg;

   localparam int KEY_W           = 32;
   localparam int POS_W           = 11;
   localparam int KIND_W          = 3;
   localparam int SEL_W           = 3;
   localparam int TABLE_DEPTH_DEF = 1024;

   localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd1;
   localparam logic [KIND_W-1:0] KIND_PRED   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SUCC   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RANK   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_SELECT = 3'd5;
   localparam logic [KIND_W-1:0] KIND_MIN    = 3'd6;
   localparam logic [KIND_W-1:0] KIND_MAX    = 3'd7;

   localparam logic [SEL_W-1:0] RD_MID    = 3'd0;
   localparam logic [SEL_W-1:0] RD_LB     = 3'd1;
   localparam logic [SEL_W-1:0] RD_PREV   = 3'd2;
   localparam logic [SEL_W-1:0] RD_NEXT   = 3'd3;
   localparam logic [SEL_W-1:0] RD_DIRECT = 3'd4;

   localparam logic [SEL_W-1:0] RES_NONE     = 3'd0;
   localparam logic [SEL_W-1:0] RES_WRITE    = 3'd1;
   localparam logic [SEL_W-1:0] RES_RDATA    = 3'd2;
   localparam logic [SEL_W-1:0] RES_SEARCH   = 3'd3;
   localparam logic [SEL_W-1:0] RES_RANK     = 3'd4;
   localparam logic [SEL_W-1:0] RES_RANK_HIT = 3'd5;

   typedef struct packed {
      logic             load;
      logic             step;
      logic             rd_en;
      logic [SEL_W-1:0] rd_sel;
      logic             wr_en;
      logic             res_en;
      logic [SEL_W-1:0] res_sel;
      logic             post;
   } cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              more;
      logic              lo_in;
      logic              hit;
      logic              pred_ok;
      logic              succ_ok;
      logic              write_ok;
      logic              direct_ok;
   } sts_type;

endpackage

FILE: rtl/core/stoq_req_if.sv
interface stoq_req_if;
   logic                                valid;
   logic                                ready;
   logic [stoq_pkg::KIND_W-1:0]         kind;
   logic signed [stoq_pkg::KEY_W-1:0]   key;
   logic [stoq_pkg::POS_W-1:0]          index;

   modport source (output valid, kind, key, index, input ready);
   modport sink (input valid, kind, key, index, output ready);
endinterface

FILE: rtl/core/stoq_rsp_if.sv
interface stoq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                found;
   logic signed [stoq_pkg::KEY_W-1:0]   value;
   logic [stoq_pkg::POS_W-1:0]          position;

   modport source (output valid, found, value, position, input ready);
   modport sink (input valid, found, value, position, output ready);
endinterface

FILE: rtl/core/stoq_ram.sv
module stoq_ram #(
   parameter int WIDTH = stoq_pkg::KEY_W,
   parameter int DEPTH = stoq_pkg::TABLE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/core/stoq_datapath.sv
module stoq_datapath #(
   parameter int TABLE_DEPTH = stoq_pkg::TABLE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [stoq_pkg::POS_W-1:0]        csr_wdata,
   input  logic [stoq_pkg::KIND_W-1:0]       req_kind,
   input  logic signed [stoq_pkg::KEY_W-1:0] req_key,
   input  logic [stoq_pkg::POS_W-1:0]        req_index,
   input  stoq_pkg::cmd_type                 cmd,
   output stoq_pkg::sts_type                 sts,
   output logic                              rsp_found,
   output logic signed [stoq_pkg::KEY_W-1:0] rsp_value,
   output logic [stoq_pkg::POS_W-1:0]        rsp_position
);

   localparam int POS_W   = stoq_pkg::POS_W;
   localparam int KEY_W   = stoq_pkg::KEY_W;
   localparam int AW      = $clog2(TABLE_DEPTH);
   localparam int WW      = (AW > POS_W) ? AW : POS_W;
   localparam int POS_MAX = (1 << POS_W) - 1;
   localparam int N_CAP   = (TABLE_DEPTH > POS_MAX) ? POS_MAX : TABLE_DEPTH;
   localparam int WR_LIM  = (TABLE_DEPTH > POS_MAX) ? POS_MAX + 1 : TABLE_DEPTH;

   logic [POS_W-1:0]        used_count_ff;
   logic [stoq_pkg::KIND_W-1:0] kind_ff;
   logic signed [KEY_W-1:0] key_ff;
   logic [POS_W-1:0]        idx_ff;
   logic [POS_W-1:0]        n_ff;
   logic [POS_W-1:0]        lo_ff;
   logic [POS_W-1:0]        hi_ff;
   logic [POS_W-1:0]        rd_pos_ff;
   logic                    res_found_ff;
   logic [KEY_W-1:0]        res_value_ff;
   logic [POS_W-1:0]        res_pos_ff;
   logic                    rsp_found_ff;
   logic [KEY_W-1:0]        rsp_value_ff;
   logic [POS_W-1:0]        rsp_pos_ff;

   logic [POS_W-1:0] n_cur;
   logic [KEY_W-1:0] rdata;
   logic             lt;
   logic [POS_W-1:0] cur_lo;
   logic [POS_W-1:0] cur_hi;
   logic [POS_W-1:0] mid;
   logic [POS_W-1:0] direct_pos;
   logic [POS_W-1:0] rd_pos;
   logic [WW-1:0]    rd_wide;
   logic [WW-1:0]    wr_wide;
   logic [AW-1:0]    rd_addr;
   logic [AW-1:0]    wr_addr;

   assign n_cur = (used_count_ff > POS_W'(N_CAP)) ? POS_W'(N_CAP) : used_count_ff;

   assign lt     = $signed(rdata) < key_ff;
   assign cur_lo = (cmd.step && lt) ? rd_pos_ff + POS_W'(1) : lo_ff;
   assign cur_hi = (cmd.step && !lt) ? rd_pos_ff : hi_ff;
   assign mid    = cur_lo + ((cur_hi - cur_lo) >> 1);

   always_comb begin
      if (kind_ff == stoq_pkg::KIND_SELECT) begin
         direct_pos = idx_ff - POS_W'(1);
      end else if (kind_ff == stoq_pkg::KIND_MAX) begin
         direct_pos = n_ff - POS_W'(1);
      end else begin
         direct_pos = '0;
      end
   end

   always_comb begin
      unique case (cmd.rd_sel)
         stoq_pkg::RD_MID:    rd_pos = mid;
         stoq_pkg::RD_LB:     rd_pos = cur_lo;
         stoq_pkg::RD_PREV:   rd_pos = lo_ff - POS_W'(1);
         stoq_pkg::RD_NEXT:   rd_pos = lo_ff + POS_W'(1);
         stoq_pkg::RD_DIRECT: rd_pos = direct_pos;
         default:             rd_pos = mid;
      endcase
   end

   assign rd_wide = WW'(rd_pos);
   assign wr_wide = WW'(idx_ff);
   assign rd_addr = rd_wide[AW-1:0];
   assign wr_addr = wr_wide[AW-1:0];

   assign sts.kind      = kind_ff;
   assign sts.more      = cur_lo < cur_hi;
   assign sts.lo_in     = cur_lo < n_ff;
   assign sts.hit       = rdata == key_ff;
   assign sts.pred_ok   = lo_ff != '0;
   assign sts.succ_ok   = (lo_ff + POS_W'(1)) < n_ff;
   assign sts.write_ok  = {1'b0, idx_ff} < (POS_W + 1)'(WR_LIM);
   assign sts.direct_ok = (kind_ff == stoq_pkg::KIND_SELECT)
                        ? (idx_ff != '0 && idx_ff <= n_ff) : (n_ff != '0);

   stoq_ram #(
      .WIDTH (KEY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (cmd.wr_en),
      .waddr (wr_addr),
      .wdata (key_ff),
      .re    (cmd.rd_en),
      .raddr (rd_addr),
      .rdata (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         used_count_ff <= '0;
      end else if (csr_we) begin
         used_count_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         key_ff  <= req_key;
         idx_ff  <= req_index;
         n_ff    <= n_cur;
         lo_ff   <= '0;
         hi_ff   <= n_cur;
      end else if (cmd.step) begin
         lo_ff <= cur_lo;
         hi_ff <= cur_hi;
      end
      if (cmd.rd_en) begin
         rd_pos_ff <= rd_pos;
      end
      if (cmd.res_en) begin
         unique case (cmd.res_sel)
            stoq_pkg::RES_WRITE: begin
               res_found_ff <= 1'b1;
               res_value_ff <= key_ff;
               res_pos_ff   <= idx_ff;
            end
            stoq_pkg::RES_RDATA: begin
               res_found_ff <= 1'b1;
               res_value_ff <= rdata;
               res_pos_ff   <= rd_pos_ff;
            end
            stoq_pkg::RES_SEARCH: begin
               res_found_ff <= 1'b1;
               res_value_ff <= key_ff;
               res_pos_ff   <= lo_ff;
            end
            stoq_pkg::RES_RANK: begin
               res_found_ff <= 1'b1;
               res_value_ff <= '0;
               res_pos_ff   <= cur_lo;
            end
            stoq_pkg::RES_RANK_HIT: begin
               res_found_ff <= 1'b1;
               res_value_ff <= '0;
               res_pos_ff   <= lo_ff + POS_W'(1);
            end
            default: begin
               res_found_ff <= 1'b0;
               res_value_ff <= '0;
               res_pos_ff   <= '0;
            end
         endcase
      end
      if (cmd.post) begin
         rsp_found_ff <= res_found_ff;
         rsp_value_ff <= res_value_ff;
         rsp_pos_ff   <= res_pos_ff;
      end
   end

   assign rsp_found    = rsp_found_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_position = rsp_pos_ff;

endmodule

FILE: rtl/core/stoq_ctrl.sv
module stoq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  stoq_pkg::sts_type sts,
   output stoq_pkg::cmd_type cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DISPATCH = 3'd1;
   localparam logic [2:0] S_CMP      = 3'd2;
   localparam logic [2:0] S_PROBE    = 3'd3;
   localparam logic [2:0] S_NBR      = 3'd4;
   localparam logic [2:0] S_POST     = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       win_rd_en;
   logic [2:0] win_state;
   logic [stoq_pkg::SEL_W-1:0] win_rd_sel;
   logic [stoq_pkg::SEL_W-1:0] win_res_sel;

   // next step of the lower-bound search from the current window
   always_comb begin
      win_rd_en   = 1'b0;
      win_rd_sel  = stoq_pkg::RD_MID;
      win_res_sel = stoq_pkg::RES_NONE;
      priority if (sts.more) begin
         win_rd_en  = 1'b1;
         win_rd_sel = stoq_pkg::RD_MID;
         win_state  = S_CMP;
      end else if (sts.lo_in) begin
         win_rd_en  = 1'b1;
         win_rd_sel = stoq_pkg::RD_LB;
         win_state  = S_PROBE;
      end else begin
         win_res_sel = (sts.kind == stoq_pkg::KIND_RANK) ? stoq_pkg::RES_RANK
                                                         : stoq_pkg::RES_NONE;
         win_state   = S_POST;
      end
   end

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (sts.kind)
               stoq_pkg::KIND_WRITE: begin
                  cmd.wr_en   = sts.write_ok;
                  cmd.res_en  = 1'b1;
                  cmd.res_sel = sts.write_ok ? stoq_pkg::RES_WRITE : stoq_pkg::RES_NONE;
                  state_in    = S_POST;
               end
               stoq_pkg::KIND_SELECT, stoq_pkg::KIND_MIN, stoq_pkg::KIND_MAX: begin
                  if (sts.direct_ok) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = stoq_pkg::RD_DIRECT;
                     state_in   = S_NBR;
                  end else begin
                     cmd.res_en  = 1'b1;
                     cmd.res_sel = stoq_pkg::RES_NONE;
                     state_in    = S_POST;
                  end
               end
               default: begin
                  cmd.rd_en   = win_rd_en;
                  cmd.rd_sel  = win_rd_sel;
                  cmd.res_en  = !win_rd_en;
                  cmd.res_sel = win_res_sel;
                  state_in    = win_state;
               end
            endcase
         end
         S_CMP: begin
            cmd.step    = 1'b1;
            cmd.rd_en   = win_rd_en;
            cmd.rd_sel  = win_rd_sel;
            cmd.res_en  = !win_rd_en;
            cmd.res_sel = win_res_sel;
            state_in    = win_state;
         end
         S_PROBE: begin
            cmd.res_en  = 1'b1;
            cmd.res_sel = stoq_pkg::RES_NONE;
            state_in    = S_POST;
            unique case (sts.kind)
               stoq_pkg::KIND_SEARCH: begin
                  cmd.res_sel = sts.hit ? stoq_pkg::RES_SEARCH : stoq_pkg::RES_NONE;
               end
               stoq_pkg::KIND_RANK: begin
                  cmd.res_sel = sts.hit ? stoq_pkg::RES_RANK_HIT : stoq_pkg::RES_RANK;
               end
               stoq_pkg::KIND_PRED: begin
                  if (sts.hit && sts.pred_ok) begin
                     cmd.res_en = 1'b0;
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = stoq_pkg::RD_PREV;
                     state_in   = S_NBR;
                  end
               end
               stoq_pkg::KIND_SUCC: begin
                  if (sts.hit && sts.succ_ok) begin
                     cmd.res_en = 1'b0;
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = stoq_pkg::RD_NEXT;
                     state_in   = S_NBR;
                  end
               end
               default: begin
                  cmd.res_sel = stoq_pkg::RES_NONE;
               end
            endcase
         end
         S_NBR: begin
            cmd.res_en  = 1'b1;
            cmd.res_sel = stoq_pkg::RES_RDATA;
            state_in    = S_POST;
         end
         S_POST: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.post     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/core/sorted_table_order_queries.sv
// Sorted table order queries.
// req_ch carries one item per valid/ready handshake: kind, key, index. Writes
// store a key at a 0-based position; the other kinds query the ascending table
// (search, predecessor, successor, rank, 1-based select, minimum, maximum).
// rsp_ch returns exactly one item (found, value, position) per request item.
// csr_we/csr_wdata set the used entry count; write it only while idle.
// One item is in work at a time; req_ch.ready is high only when idle.
// A write posts its result without a table read; select, minimum and maximum
// make one direct read when the position is in range. The other kinds run a
// binary search (at most floor(log2(n))+1 steps, 11 for 1024 entries), probe
// the lower bound if it lies below n, and predecessor and successor then read
// a neighbour on a hit; an empty table answers without a read. Each search
// step is one read of the single table RAM port, compared against the key in
// the next cycle. The next item is accepted the cycle after a result posts.
// A finished item sits in the output register; if the receiver stalls, the
// block holds its next result in the final state until that register frees,
// while the item after it is accepted only then.
// Reset clears the control state and the used count to zero; table contents
// are undefined until written.
module sorted_table_order_queries #(
   parameter int TABLE_DEPTH = stoq_pkg::TABLE_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [stoq_pkg::POS_W-1:0] csr_wdata,
   stoq_req_if.sink                   req_ch,
   stoq_rsp_if.source                 rsp_ch
);

   stoq_pkg::cmd_type cmd;
   stoq_pkg::sts_type sts;

   stoq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   stoq_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .req_kind     (req_ch.kind),
      .req_key      (req_ch.key),
      .req_index    (req_ch.index),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_found    (rsp_ch.found),
      .rsp_value    (rsp_ch.value),
      .rsp_position (rsp_ch.position)
   );

`ifndef ASSERT_OFF
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("item accepted while another is in work");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.found) |-> (rsp_ch.value == '0 && rsp_ch.position == '0))
      else $error("not-found result carries nonzero payload");

   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(!req_ch.ready))
      else $error("result raised without an item in work");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (req_ch.valid && req_ch.ready && !cmd.post))
      else $error("item loaded outside the accept handshake");
`endif

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int KEY_W       = stoq_pkg::KEY_W;
   localparam int POS_W       = stoq_pkg::POS_W;
   localparam int KIND_W      = stoq_pkg::KIND_W;
   localparam int DEPTH       = stoq_pkg::TABLE_DEPTH_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 24;

   typedef struct {
      logic                    found;
      logic signed [KEY_W-1:0] value;
      logic [POS_W-1:0]        position;
   } query_answer_type;

   class order_scoreboard;
      logic signed [KEY_W-1:0] key_store [DEPTH];
      logic [POS_W-1:0]        used_reg;
      query_answer_type        pending_answers [$];
      int unsigned             mismatches;
      int unsigned             checked;
      int unsigned             hits;
      int unsigned             misses;

      function new();
         foreach (key_store[i]) key_store[i] = '0;
         used_reg   = '0;
         mismatches = 0;
         checked    = 0;
         hits       = 0;
         misses     = 0;
      endfunction

      function void set_used_count(logic [POS_W-1:0] count);
         used_reg = count;
      endfunction

      function int unsigned live_entries();
         return (used_reg > DEPTH) ? DEPTH : used_reg;
      endfunction

      function int unsigned lower_bound(logic signed [KEY_W-1:0] key, int unsigned n);
         int unsigned lo;
         int unsigned hi;
         int unsigned mid;
         lo = 0;
         hi = n;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (key_store[mid] < key) lo = mid + 1;
            else hi = mid;
         end
         return lo;
      endfunction

      function void note_item(logic [KIND_W-1:0] kind, logic signed [KEY_W-1:0] key,
                              logic [POS_W-1:0] index);
         query_answer_type want;
         int unsigned      n;
         int unsigned      lb;
         int unsigned      pos;
         bit               hit;
         want = '{1'b0, '0, '0};
         n = live_entries();
         case (kind)
            stoq_pkg::KIND_WRITE: begin
               if (index < DEPTH) begin
                  key_store[index] = key;
                  want = '{1'b1, key, index};
               end
            end
            stoq_pkg::KIND_SELECT: begin
               if (index >= 1 && index <= n)
                  want = '{1'b1, key_store[index - 1], POS_W'(index - 1)};
            end
            stoq_pkg::KIND_MIN, stoq_pkg::KIND_MAX: begin
               if (n != 0) begin
                  pos = (kind == stoq_pkg::KIND_MIN) ? 0 : n - 1;
                  want = '{1'b1, key_store[pos], POS_W'(pos)};
               end
            end
            default: begin
               lb = lower_bound(key, n);
               hit = 1'b0;
               if (lb < n) hit = (key_store[lb] == key);
               case (kind)
                  stoq_pkg::KIND_SEARCH: if (hit) want = '{1'b1, key, POS_W'(lb)};
                  stoq_pkg::KIND_PRED: begin
                     if (hit && lb != 0)
                        want = '{1'b1, key_store[lb - 1], POS_W'(lb - 1)};
                  end
                  stoq_pkg::KIND_SUCC: begin
                     if (hit && lb + 1 < n)
                        want = '{1'b1, key_store[lb + 1], POS_W'(lb + 1)};
                  end
                  default: want = '{1'b1, '0, POS_W'(lb + hit)};
               endcase
            end
         endcase
         if (want.found) hits++;
         else misses++;
         pending_answers.push_back(want);
      endfunction

      function void check_item(logic found, logic signed [KEY_W-1:0] value,
                               logic [POS_W-1:0] position);
         query_answer_type want;
         checked++;
         if (pending_answers.size() == 0) begin
            $error("unexpected result item: found=%0b value=%0d position=%0d",
                   found, value, position);
            mismatches++;
            return;
         end
         want = pending_answers.pop_front();
         if (found !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, found);
            mismatches++;
         end
         if (value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, value);
            mismatches++;
         end
         if (position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, position);
            mismatches++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [POS_W-1:0] csr_wdata;
   bit               calm;
   int unsigned      items_sent;
   int unsigned      sizes_set;
   int unsigned      cycles;

   order_scoreboard board = new();

   stoq_req_if req_ch ();
   stoq_rsp_if rsp_ch ();

   sorted_table_order_queries dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic hold_off();
      while (!calm && $urandom_range(99) < 14) begin
         req_ch.valid <= 1'b0;
         req_ch.kind  <= KIND_W'($urandom);
         req_ch.key   <= KEY_W'($urandom);
         req_ch.index <= POS_W'($urandom);
         @(posedge clock);
      end
   endtask

   task automatic send_item(input logic [KIND_W-1:0] kind, input logic signed [KEY_W-1:0] key,
                            input logic [POS_W-1:0] index);
      hold_off();
      req_ch.valid <= 1'b1;
      req_ch.kind  <= kind;
      req_ch.key   <= key;
      req_ch.index <= index;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      board.note_item(kind, key, index);
      items_sent++;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (board.pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic write_used_count(input logic [POS_W-1:0] count);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= count;
      @(posedge clock);
      csr_we <= 1'b0;
      board.set_used_count(count);
      sizes_set++;
   endtask

   // fill positions 0..m-1 with an ascending run, dense with repeats or spread wide
   task automatic fill_ascending(input int unsigned m);
      longint cur;
      longint span;
      bit     narrow;
      narrow = $urandom_range(1);
      span = 64'h1_0000_0000 / (m + 1);
      if (narrow) cur = longint'($urandom_range(20)) - 10;
      else cur = -64'sd2147483648 + longint'($urandom_range(32'(span - 1)));
      for (int unsigned i = 0; i < m; i++) begin
         send_item(stoq_pkg::KIND_WRITE, cur[KEY_W-1:0], POS_W'(i));
         if (narrow) cur += $urandom_range(2);
         else cur += $urandom_range(32'(span - 1));
         if (cur > 64'sd2147483647) cur = 64'sd2147483647;
      end
   endtask

   // write only the entries read on the search paths toward either end of the table
   task automatic fill_search_paths();
      for (int unsigned stride = 1; stride < DEPTH; stride *= 2) begin
         send_item(stoq_pkg::KIND_WRITE, KEY_W'(stride * 1000), POS_W'(stride));
         if (DEPTH - stride > stride)
            send_item(stoq_pkg::KIND_WRITE, KEY_W'((DEPTH - stride) * 1000),
                      POS_W'(DEPTH - stride));
      end
      send_item(stoq_pkg::KIND_WRITE, 32'sh8000_0000, 11'd0);
   endtask

   task automatic probe_full_table(input logic [POS_W-1:0] count);
      write_used_count(count);
      send_item(stoq_pkg::KIND_MIN, 32'sd0, 11'd0);
      send_item(stoq_pkg::KIND_MAX, 32'sd0, 11'd0);
      send_item(stoq_pkg::KIND_SELECT, 32'sd0, 11'd1);
      send_item(stoq_pkg::KIND_SELECT, 32'sd0, POS_W'(DEPTH));
      send_item(stoq_pkg::KIND_SELECT, 32'sd0, POS_W'(DEPTH + 1));
      send_item(stoq_pkg::KIND_SEARCH, 32'sh8000_0000, 11'd0);
      send_item(stoq_pkg::KIND_PRED, 32'sh8000_0000, 11'd0);
      send_item(stoq_pkg::KIND_SUCC, 32'sh8000_0000, 11'd0);
      send_item(stoq_pkg::KIND_RANK, 32'sh8000_0000, 11'd0);
      send_item(stoq_pkg::KIND_SEARCH, 32'sh7fff_ffff, 11'd0);
      send_item(stoq_pkg::KIND_PRED, 32'sh7fff_ffff, 11'd0);
      send_item(stoq_pkg::KIND_SUCC, 32'sh7fff_ffff, 11'd0);
      send_item(stoq_pkg::KIND_RANK, 32'sh7fff_ffff, 11'd0);
   endtask

   task automatic random_query(input int unsigned n);
      logic [KIND_W-1:0]       kind;
      logic signed [KEY_W-1:0] key;
      logic [POS_W-1:0]        index;
      int unsigned             pick;
      kind = KIND_W'($urandom_range(stoq_pkg::KIND_SEARCH, stoq_pkg::KIND_MAX));
      pick = $urandom_range(99);
      if (n != 0 && pick < 50) begin
         key = board.key_store[$urandom_range(n - 1)];
      end else if (n != 0 && pick < 65) begin
         key = board.key_store[$urandom_range(n - 1)] + ($urandom_range(1) ? 1 : -1);
      end else if (pick < 75) begin
         case ($urandom_range(2))
            0: key = 32'h8000_0000;
            1: key = 32'h7fff_ffff;
            default: key = '0;
         endcase
      end else begin
         key = KEY_W'($urandom);
      end
      if (kind == stoq_pkg::KIND_SELECT && $urandom_range(99) < 80)
         index = POS_W'($urandom_range(n + 1));
      else index = POS_W'($urandom);
      send_item(kind, key, index);
   endtask

   task automatic random_write(input int unsigned n);
      logic [POS_W-1:0] index;
      int unsigned      pick;
      pick = $urandom_range(99);
      if (n != 0 && pick < 20) index = POS_W'($urandom_range(n - 1));
      else if (pick < 60 || n >= DEPTH) index = POS_W'($urandom_range(DEPTH, 2 ** POS_W - 1));
      else index = POS_W'($urandom_range(n, DEPTH - 1));
      send_item(stoq_pkg::KIND_WRITE, KEY_W'($urandom), index);
   endtask

   task automatic run_phase(input logic [POS_W-1:0] count, input bit refill,
                            input int unsigned queries);
      int unsigned n;
      n = (count > DEPTH) ? DEPTH : count;
      if (refill) fill_ascending(n);
      write_used_count(count);
      repeat (queries) begin
         if ($urandom_range(99) < 3) drain();
         if ($urandom_range(99) < 10) random_write(n);
         else random_query(n);
      end
   endtask

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            board.check_item(rsp_ch.found, rsp_ch.value, rsp_ch.position);
         rsp_ch.ready <= calm || ($urandom_range(99) >= 14);
      end
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("testbench: FAIL");
      $finish;
   end

   initial begin
      reset        <= 1'b1;
      csr_we       <= 1'b0;
      csr_wdata    <= '0;
      req_ch.valid <= 1'b0;
      req_ch.kind  <= '0;
      req_ch.key   <= '0;
      req_ch.index <= '0;
      calm       = 1'b0;
      items_sent = 0;
      sizes_set  = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty table
      send_item(stoq_pkg::KIND_SEARCH, 32'sd0, 11'd0);
      send_item(stoq_pkg::KIND_PRED, 32'sd0, 11'd0);
      send_item(stoq_pkg::KIND_SUCC, 32'sd0, 11'd0);
      send_item(stoq_pkg::KIND_RANK, 32'sd0, 11'd0);
      send_item(stoq_pkg::KIND_SELECT, 32'sd0, 11'd1);
      send_item(stoq_pkg::KIND_MIN, 32'sd0, 11'd0);
      send_item(stoq_pkg::KIND_MAX, 32'sd0, 11'd0);
      send_item(stoq_pkg::KIND_WRITE, -32'sd1, 11'h7ff);
      send_item(stoq_pkg::KIND_WRITE, 32'sd5, 11'd1024);

      send_item(stoq_pkg::KIND_WRITE, 32'sh8000_0000, 11'd0);
      send_item(stoq_pkg::KIND_WRITE, -32'sd5, 11'd1);
      send_item(stoq_pkg::KIND_WRITE, 32'sd7, 11'd2);
      send_item(stoq_pkg::KIND_WRITE, 32'sd7, 11'd3);
      send_item(stoq_pkg::KIND_WRITE, 32'sd100, 11'd4);
      send_item(stoq_pkg::KIND_WRITE, 32'sh7fff_ffff, 11'd5);
      write_used_count(11'd6);
      send_item(stoq_pkg::KIND_SEARCH, 32'sd7, 11'd0);
      send_item(stoq_pkg::KIND_SEARCH, 32'sd8, 11'd0);
      send_item(stoq_pkg::KIND_PRED, 32'sh8000_0000, 11'd0);
      send_item(stoq_pkg::KIND_PRED, 32'sd7, 11'd0);
      send_item(stoq_pkg::KIND_SUCC, 32'sd7, 11'd0);
      send_item(stoq_pkg::KIND_SUCC, 32'sh7fff_ffff, 11'd0);
      send_item(stoq_pkg::KIND_RANK, 32'sd7, 11'd0);
      send_item(stoq_pkg::KIND_RANK, 32'sh7fff_ffff, 11'd0);
      send_item(stoq_pkg::KIND_SELECT, 32'sd0, 11'd0);
      send_item(stoq_pkg::KIND_SELECT, 32'sd0, 11'd6);
      send_item(stoq_pkg::KIND_SELECT, 32'sd0, 11'd7);
      send_item(stoq_pkg::KIND_MIN, 32'sd0, 11'd0);
      send_item(stoq_pkg::KIND_MAX, 32'sd0, 11'd0);

      // search lands past the last used entry
      write_used_count(11'd4);
      send_item(stoq_pkg::KIND_SEARCH, 32'sd100, 11'd0);
      send_item(stoq_pkg::KIND_RANK, 32'sd100, 11'd0);

      run_phase(11'd0, 1'b1, 30);
      run_phase(11'd1, 1'b1, 30);
      run_phase(11'd2, 1'b1, 30);
      run_phase(11'd3, 1'b1, 30);

      // full and oversized counts over a table written along the search paths
      fill_search_paths();
      probe_full_table(11'h7ff);
      probe_full_table(11'd1024);
      send_item(stoq_pkg::KIND_WRITE, 32'sh7fff_ffff, POS_W'(DEPTH - 1));
      probe_full_table(11'd1024);

      calm = 1'b1;
      run_phase(11'd48, 1'b1, 60);
      calm = 1'b0;
      repeat (3) run_phase(POS_W'($urandom_range(4, 64)), 1'b1, 35);

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("testbench: %0d request items sent over %0d table sizes, %0d results checked",
               items_sent, sizes_set, board.checked);
      $display("testbench: %0d answers with found set, %0d without, %0d mismatches",
               board.hits, board.misses, board.mismatches);
      if (board.mismatches == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
